@@ design/atsi_pkg.sv @@
// Shared types, constants and helper functions for the ADC table search/interpolate block.
package atsi_pkg;

  // Default calibration table depth
  localparam int TABLE_DEPTH_DEF = 256;

  // Field widths fixed by the interface
  localparam int WORD_W     = 16;
  localparam int POS_W      = 8;
  localparam int TEMP_W     = 13;
  localparam int FOUND_W    = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // Command queue between front and back end (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  // Arithmetic widths
  localparam int TEMP_ACC_W = 24;  // temperature accumulator, signed
  localparam int IDX_ARG_W  = 11;  // holds any table position up to 1024
  localparam int NUM_MAG_W  = 20;  // |10*(lo - sample)| < 2^20
  localparam int DIV_STEPS  = NUM_MAG_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int TEMP_MAX   = 4095;
  localparam int TEMP_MIN   = -4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MAX      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MIN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF       = 2'd3;

  typedef enum logic [0:0] {
    CMD_LOAD    = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INTERP     = 2'd0,
    ST_CLAMP_HIGH = 2'd1,
    ST_CLAMP_LOW  = 2'd2,
    ST_FLAT       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_PROBE,
    BS_CMP,
    BS_RDLO,
    BS_RDHI,
    BS_DIV,
    BS_DONE
  } back_state_t;

  typedef struct packed {
    cmd_t              command;
    logic [POS_W-1:0]  entry_index;
    logic [WORD_W-1:0] table_word;
    logic [WORD_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [FOUND_W-1:0]       found_index;
    status_t                  status;
  } out_item_t;

  // Decoded operation held in the command queue
  typedef struct packed {
    cmd_t              kind;
    logic [POS_W-1:0]  addr;
    logic [WORD_W-1:0] data;  // table word for a load, sample for a convert
  } op_t;

  typedef struct packed {
    logic [8:0]        entries_in_use;
    logic [8:0]        index_max;
    logic [7:0]        index_min;
    logic signed [7:0] temp_ref;
  } cfg_t;

  // 10 * (pos + ref_deg - 1), tenths of a degree at a table position
  function automatic logic signed [TEMP_ACC_W-1:0] ten_deg(
      input logic [IDX_ARG_W-1:0] pos,
      input logic signed [7:0]    ref_deg);
    logic signed [TEMP_ACC_W-1:0] s;
    s = $signed(TEMP_ACC_W'(pos)) + TEMP_ACC_W'(ref_deg) - TEMP_ACC_W'(1);
    return (s <<< 3) + (s <<< 1);
  endfunction

  // Saturate to the 13-bit signed temperature range
  function automatic logic signed [TEMP_W-1:0] sat_temp(
      input logic signed [TEMP_ACC_W-1:0] t);
    logic signed [TEMP_W-1:0] r;
    if (t > TEMP_ACC_W'(TEMP_MAX)) begin
      r = TEMP_W'(TEMP_MAX);
    end else if (t < TEMP_ACC_W'(TEMP_MIN)) begin
      r = TEMP_W'(TEMP_MIN);
    end else begin
      r = TEMP_W'(t);
    end
    return r;
  endfunction

endpackage

@@ design/atsi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module atsi_ram #(
  parameter int WIDTH = atsi_pkg::WORD_W,
  parameter int DEPTH = atsi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/atsi_front.sv @@
// Front end: accepts input beats, decodes them and queues operations for the back end.
module atsi_front #(
  parameter int TABLE_DEPTH = atsi_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  atsi_pkg::in_item_t item,
  output logic               q_empty,
  output atsi_pkg::op_t      q_head,
  input  logic               q_pop
);

  atsi_pkg::op_t            q_mem [atsi_pkg::QUEUE_DEPTH];
  logic [atsi_pkg::QAW-1:0] wr_ptr;
  logic [atsi_pkg::QAW-1:0] rd_ptr;
  logic [atsi_pkg::QAW:0]   count;

  logic          accept;
  logic          keep;
  logic          q_write;
  logic          q_read;
  atsi_pkg::op_t op_in;

  // Decode: loads past the end of the table are dropped here
  always_comb begin
    accept      = push && !full;
    keep        = (item.command == atsi_pkg::CMD_CONVERT) ||
                  (32'(item.entry_index) < TABLE_DEPTH);
    q_write     = accept && keep;
    q_read      = q_pop && !q_empty;
    op_in.kind  = item.command;
    op_in.addr  = item.entry_index;
    op_in.data  = (item.command == atsi_pkg::CMD_CONVERT) ? item.sample : item.table_word;
  end

  assign full    = (count == (atsi_pkg::QAW+1)'(atsi_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign q_head  = q_mem[rd_ptr];

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_write) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_read) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (q_write && !q_read) begin
        count <= count + 1'b1;
      end else if (!q_write && q_read) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (q_write) begin
      q_mem[wr_ptr] <= op_in;
    end
  end

endmodule

@@ design/atsi_back.sv @@
// Back end: table writes, binary search, interpolation with a bit-serial divider.
module atsi_back #(
  parameter int TABLE_DEPTH = atsi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  atsi_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  atsi_pkg::op_t       q_head,
  output logic                q_pop,
  output logic                res_valid,
  output atsi_pkg::out_item_t res,
  input  logic                pop
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (IW > 9) ? IW : 9;
  localparam int TW = atsi_pkg::TEMP_ACC_W;
  localparam int NW = atsi_pkg::NUM_MAG_W;

  atsi_pkg::back_state_t state, state_next;

  logic [IW-1:0]                  low, low_next;
  logic [IW-1:0]                  high, high_next;
  logic [IW-1:0]                  mid, mid_next;
  logic [atsi_pkg::WORD_W-1:0]    sample, sample_next;
  logic [atsi_pkg::WORD_W-1:0]    lo_word, lo_word_next;
  logic signed [TW-1:0]           base, base_next;
  logic signed [TW-1:0]           frac, frac_next;
  atsi_pkg::status_t              status, status_next;
  logic [NW-1:0]                  quo, quo_next;
  logic [atsi_pkg::WORD_W-1:0]    rem, rem_next;
  logic [atsi_pkg::WORD_W-1:0]    den_mag, den_mag_next;
  logic                           neg, neg_next;
  logic [atsi_pkg::DIV_CNT_W-1:0] cnt, cnt_next;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [atsi_pkg::WORD_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [atsi_pkg::WORD_W-1:0] ram_rdata;

  logic [CW-1:0]        ent;
  logic [CW-1:0]        n_use;
  logic [IW-1:0]        high_init;
  logic [IW:0]          mid_sum;
  logic [IW-1:0]        mid_calc;
  logic [IW-1:0]        idx_prev;
  logic [CW-1:0]        lidx;
  logic                 clamp_hi;
  logic                 clamp_lo;
  logic signed [16:0]   diff17;
  logic signed [20:0]   num21;
  logic signed [16:0]   den17;
  logic [16:0]          rem_sh;
  logic                 ge;
  logic [NW-1:0]        q_step;
  logic signed [TW-1:0] t_sum;
  logic                 done_write;

  atsi_ram #(
    .WIDTH (atsi_pkg::WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Search range setup and clamp decisions
  always_comb begin
    ent       = CW'(cfg.entries_in_use);
    if (ent == '0) begin
      n_use = CW'(1);
    end else if (ent > CW'(TABLE_DEPTH)) begin
      n_use = CW'(TABLE_DEPTH);
    end else begin
      n_use = ent;
    end
    high_init = IW'(n_use - CW'(1));
    mid_sum   = {1'b0, low} + {1'b0, high};
    mid_calc  = mid_sum[IW:1];
    idx_prev  = low - IW'(1);
    lidx      = CW'(low);
    clamp_hi  = (lidx >= CW'(cfg.index_max)) ||
                ((lidx > CW'(cfg.index_min)) && (lidx >= CW'(TABLE_DEPTH)));
    clamp_lo  = (lidx <= CW'(cfg.index_min));
  end

  // Interpolation operands and divider step
  always_comb begin
    diff17 = $signed({1'b0, lo_word}) - $signed({1'b0, sample});
    num21  = (21'(diff17) <<< 3) + (21'(diff17) <<< 1);
    den17  = $signed({1'b0, lo_word}) - $signed({1'b0, ram_rdata});
    rem_sh = {rem, quo[NW-1]};
    ge     = (rem_sh >= {1'b0, den_mag});
    q_step = {quo[NW-2:0], ge};
    t_sum  = frac + base;
  end

  // Sequencer
  always_comb begin
    state_next   = state;
    low_next     = low;
    high_next    = high;
    mid_next     = mid;
    sample_next  = sample;
    lo_word_next = lo_word;
    base_next    = base;
    frac_next    = frac;
    status_next  = status;
    quo_next     = quo;
    rem_next     = rem;
    den_mag_next = den_mag;
    neg_next     = neg;
    cnt_next     = cnt;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = AW'(q_head.addr);
    ram_wdata    = q_head.data;
    ram_raddr    = mid_calc[AW-1:0];
    done_write   = 1'b0;

    unique case (state)
      atsi_pkg::BS_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.kind == atsi_pkg::CMD_LOAD) begin
            ram_we = 1'b1;
          end else begin
            low_next    = IW'(1);
            high_next   = high_init;
            sample_next = q_head.data;
            state_next  = atsi_pkg::BS_PROBE;
          end
        end
      end
      atsi_pkg::BS_PROBE: begin
        if (low <= high) begin
          mid_next   = mid_calc;
          state_next = atsi_pkg::BS_CMP;
        end else if (clamp_hi) begin
          base_next   = atsi_pkg::ten_deg(atsi_pkg::IDX_ARG_W'(cfg.index_max), cfg.temp_ref);
          frac_next   = '0;
          status_next = atsi_pkg::ST_CLAMP_HIGH;
          state_next  = atsi_pkg::BS_DONE;
        end else if (clamp_lo) begin
          base_next   = atsi_pkg::ten_deg(atsi_pkg::IDX_ARG_W'(cfg.index_min), cfg.temp_ref);
          frac_next   = '0;
          status_next = atsi_pkg::ST_CLAMP_LOW;
          state_next  = atsi_pkg::BS_DONE;
        end else begin
          base_next  = atsi_pkg::ten_deg(atsi_pkg::IDX_ARG_W'(low), cfg.temp_ref);
          frac_next  = '0;
          ram_raddr  = idx_prev[AW-1:0];
          state_next = atsi_pkg::BS_RDLO;
        end
      end
      atsi_pkg::BS_CMP: begin
        if (sample > ram_rdata) begin
          low_next = mid + IW'(1);
        end else begin
          high_next = mid - IW'(1);
        end
        state_next = atsi_pkg::BS_PROBE;
      end
      atsi_pkg::BS_RDLO: begin
        lo_word_next = ram_rdata;
        ram_raddr    = low[AW-1:0];
        state_next   = atsi_pkg::BS_RDHI;
      end
      atsi_pkg::BS_RDHI: begin
        if (den17 == '0) begin
          status_next = atsi_pkg::ST_FLAT;
          state_next  = atsi_pkg::BS_DONE;
        end else begin
          quo_next     = num21[20] ? NW'(-num21) : NW'(num21);
          den_mag_next = den17[16] ? atsi_pkg::WORD_W'(-den17) : atsi_pkg::WORD_W'(den17);
          rem_next     = '0;
          neg_next     = num21[20] ^ den17[16];
          cnt_next     = '0;
          status_next  = atsi_pkg::ST_INTERP;
          state_next   = atsi_pkg::BS_DIV;
        end
      end
      atsi_pkg::BS_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_next = ge ? atsi_pkg::WORD_W'(rem_sh - {1'b0, den_mag}) : rem_sh[15:0];
        quo_next = q_step;
        cnt_next = cnt + 1'b1;
        if (cnt == atsi_pkg::DIV_CNT_W'(atsi_pkg::DIV_STEPS - 1)) begin
          frac_next  = neg ? -$signed(TW'(q_step)) : $signed(TW'(q_step));
          state_next = atsi_pkg::BS_DONE;
        end
      end
      atsi_pkg::BS_DONE: begin
        if (!res_valid || pop) begin
          done_write = 1'b1;
          state_next = atsi_pkg::BS_IDLE;
        end
      end
      default: begin
        state_next = atsi_pkg::BS_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= atsi_pkg::BS_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done_write) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    low     <= low_next;
    high    <= high_next;
    mid     <= mid_next;
    sample  <= sample_next;
    lo_word <= lo_word_next;
    base    <= base_next;
    frac    <= frac_next;
    status  <= status_next;
    quo     <= quo_next;
    rem     <= rem_next;
    den_mag <= den_mag_next;
    neg     <= neg_next;
    cnt     <= cnt_next;
    if (done_write) begin
      res.temperature <= atsi_pkg::sat_temp(t_sum);
      res.found_index <= atsi_pkg::FOUND_W'(low);
      res.status      <= status;
    end
  end

endmodule

@@ design/adc_table_search_interpolate.sv @@
// Flow: a load beat is written to the table when the back end pops it from the queue; a convert
//   beat's result shows after p <= ceil(log2(entries_in_use)) search probes on the registered-read
//   table and the bit-serial divider; a clamped or flat result skips the divider.
// Throughput: one item at a time in the back end; a 4-entry command queue accepts until full.
// Reset (rst, synchronous): queues empty, registers to entries_in_use 256, index_max 255,
//   index_min 1, temp_ref 0; table contents are undefined until loaded.
module adc_table_search_interpolate #(
  parameter int TABLE_DEPTH = atsi_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  atsi_pkg::in_item_t                item,
  output logic                              empty,
  input  logic                              pop,
  output atsi_pkg::out_item_t               result,
  input  logic                              cfg_we,
  input  logic [atsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [atsi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  atsi_pkg::cfg_t cfg;
  logic           q_empty;
  atsi_pkg::op_t  q_head;
  logic           q_pop;
  logic           res_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entries_in_use <= 9'd256;
      cfg.index_max      <= 9'd255;
      cfg.index_min      <= 8'd1;
      cfg.temp_ref       <= 8'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atsi_pkg::REG_ENTRIES_IN_USE: cfg.entries_in_use <= cfg_data;
        atsi_pkg::REG_INDEX_MAX:      cfg.index_max      <= cfg_data;
        atsi_pkg::REG_INDEX_MIN:      cfg.index_min      <= cfg_data[7:0];
        atsi_pkg::REG_TEMP_REF:       cfg.temp_ref       <= $signed(cfg_data[7:0]);
      endcase
    end
  end

  atsi_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  atsi_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (result),
    .pop       (pop)
  );

  assign empty = !res_valid;

endmodule

@@ design/atsi_chk.sv @@
// Port-level checker for the ADC table search/interpolate block, bound to the top level.
module atsi_chk (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input atsi_pkg::in_item_t  item,
  input logic                empty,
  input logic                pop,
  input atsi_pkg::out_item_t result
);

  logic       conv_acc;
  logic       deliver;
  logic [3:0] pending;

  assign conv_acc = push && !full && (item.command == atsi_pkg::CMD_CONVERT);
  assign deliver  = pop && !empty;

  // Converts accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (conv_acc && !deliver) begin
      pending <= pending + 1'b1;
    end else if (!conv_acc && deliver) begin
      pending <= pending - 1'b1;
    end
  end

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (pending != '0))
    else $error("result shown with no convert outstanding");

  a_last_drained: assert property (@(posedge clk) disable iff (rst)
      (deliver && (pending == 4'd1)) |=> empty)
    else $error("result repeated after last convert was taken");

endmodule

bind adc_table_search_interpolate atsi_chk u_atsi_chk (.*);
